// ===== sv/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; compile before the interfaces and modules.
package pli_pkg;

    // Breakpoint table depth and the widths that follow from it
    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Fixed field widths
    localparam int N_PTS_W    = 5;
    localparam int PIDX_W     = 4;
    localparam int Q_W        = 32;
    localparam int PROD_W     = 2 * Q_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [N_PTS_W-1:0] N_POINTS_RESET = N_PTS_W'(2);

    // Signed Q16.16 value
    typedef logic signed [Q_W-1:0] q16_t;

    // Request kinds
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    // One breakpoint as stored in the table
    typedef struct packed {
        q16_t t;
        q16_t y;
    } bkpt_t;

endpackage

// ===== sv/pli_if.sv =====
// Valid/ready channel interfaces for the interpolator request and response beats.
// Depends on pli_pkg.
interface pli_req_if
    import pli_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [PIDX_W-1:0]   point_index;
    q16_t                point_y;
    q16_t                arg_t;

    modport source (output valid, output req_type, output point_index,
                    output point_y, output arg_t, input ready);
    modport sink   (input valid, input req_type, input point_index,
                    input point_y, input arg_t, output ready);
endinterface

interface pli_rsp_if
    import pli_pkg::*;
();
    logic  valid;
    logic  ready;
    q16_t  y_result;
    logic  out_of_range;

    modport source (output valid, output y_result, output out_of_range, input ready);
    modport sink   (input valid, input y_result, input out_of_range, output ready);
endinterface

// ===== sv/pli_div.sv =====
// Restoring divider, one quotient bit per cycle, for the interpolation fraction.
// Depends on pli_pkg. The caller guarantees dividend < divisor * 2**32 and divisor != 0.
module pli_div
    import pli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [Q_W-1:0]    divisor,
    output logic              done,
    output logic [Q_W-1:0]    quotient
);

    logic [Q_W-1:0]    rem_reg;
    logic [Q_W-1:0]    lo_reg;
    logic [Q_W-1:0]    dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [Q_W:0]      shifted;
    logic [Q_W:0]      diff;
    logic              qbit;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, lo_reg[Q_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        qbit    = ~diff[Q_W];
    end

    // Control: count the steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend bits in, quotient bits collect in lo_reg
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:Q_W];
            lo_reg  <= dividend[Q_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[Q_W-1:0] : shifted[Q_W-1:0];
            lo_reg  <= {lo_reg[Q_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

// ===== sv/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator top level: breakpoint memory, segment scan, result sum.
// Depends on pli_pkg, pli_if (pli_req_if, pli_rsp_if) and pli_div.
//
//  channel  dir  handshake        payload
//  req      in   valid/ready      req_type, point_index, point_y, arg_t
//  rsp      out  valid/ready      y_result, out_of_range
//  cfg      in   cfg_we           cfg_wdata (n_points)
//
// A load beat writes its breakpoint at the accepting edge. A query holds the input until
// its result loads into the output register: the scan reads breakpoints (up to n_points),
// then prepare, multiply, divide, sum and output load; a short table, a miss or a
// zero-width segment goes straight to the load. The breakpoint memory is read one entry a
// cycle and the divider is bit-serial. One item is in work at a time; the finished result
// sits in the output register so a new beat is taken while rsp is stalled. Reset clears
// the registers but not the breakpoint memory; the table is undefined until loaded.
module piecewise_linear_interpolator
    import pli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pli_req_if.sink            req,
    pli_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic [N_PTS_W-1:0] cfg_wdata
);

    localparam logic signed [Q_W+1:0] SUM_MAX = (Q_W+2)'(64'sh7FFF_FFFF);
    localparam logic signed [Q_W+1:0] SUM_MIN = -(Q_W+2)'(64'sh8000_0000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_SUM,
        S_FIN
    } state_t;

    state_t             state_reg;
    logic [N_PTS_W-1:0] n_points_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   n_last_reg;
    q16_t               t_q_reg;
    bkpt_t              prev_reg;
    bkpt_t              cur_reg;
    logic [Q_W-1:0]     seg_reg;
    logic [Q_W-1:0]     dt_reg;
    logic [Q_W-1:0]     mag_reg;
    logic               neg_reg;
    q16_t               y_final_reg;
    logic               oor_reg;
    logic               out_valid_reg;
    q16_t               out_y_reg;
    logic               out_oor_reg;

    // Breakpoint memory
    bkpt_t              mem [MAX_POINTS];
    bkpt_t              rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [IDX_W-1:0]   mem_ra;

    logic               req_fire;
    logic               load_fire;
    logic               query_fire;
    logic [CNT_W-1:0]   n_clip;
    logic               n_small;
    logic               in_seg;
    logic [Q_W:0]       seg_w;
    logic [Q_W:0]       dt_w;
    logic signed [Q_W:0] dy_w;
    logic [Q_W:0]       mag_w;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic signed [Q_W+1:0] sum_w;
    q16_t               sat_w;
    logic               fin_load;

    // Handshake decode
    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign load_fire  = req_fire && (req.req_type == REQ_LOAD);
    assign query_fire = req_fire && (req.req_type == REQ_QUERY);

    // Clip the point count to the table depth and flag counts below two
    always_comb
    begin
        n_clip  = (32'(n_points_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                   : CNT_W'(n_points_reg);
        n_small = (n_points_reg < N_PTS_W'(2));
    end

    // Memory port control: write loads, read the next entry of the scan, else entry 0
    assign mem_we = load_fire && (32'(req.point_index) < MAX_POINTS);
    assign mem_wa = IDX_W'(req.point_index);
    assign mem_ra = (state_reg == S_SCAN) ? IDX_W'(idx_reg + 1'b1) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= '{t: req.arg_t, y: req.point_y};
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Segment test against the entry just read
    assign in_seg = (prev_reg.t <= t_q_reg) && (t_q_reg <= rd_data_reg.t);

    // Signed segment width, offset and y step, and the magnitude of the y step
    always_comb
    begin
        seg_w = {cur_reg.t[Q_W-1], cur_reg.t} - {prev_reg.t[Q_W-1], prev_reg.t};
        dt_w  = {t_q_reg[Q_W-1], t_q_reg} - {prev_reg.t[Q_W-1], prev_reg.t};
        dy_w  = $signed({cur_reg.y[Q_W-1], cur_reg.y})
              - $signed({prev_reg.y[Q_W-1], prev_reg.y});
        mag_w = dy_w[Q_W] ? (Q_W+1)'(-dy_w) : (Q_W+1)'(dy_w);
    end

    assign div_start = (state_reg == S_MUL);

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg * dt_reg),
        .divisor  (seg_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Apply the sign of the step and saturate
    always_comb
    begin
        sum_w = neg_reg ? ($signed({{2{prev_reg.y[Q_W-1]}}, prev_reg.y})
                           - $signed({2'b00, div_q}))
                        : ($signed({{2{prev_reg.y[Q_W-1]}}, prev_reg.y})
                           + $signed({2'b00, div_q}));
        if (sum_w > SUM_MAX)
        begin
            sat_w = SUM_MAX[Q_W-1:0];
        end
        else if (sum_w < SUM_MIN)
        begin
            sat_w = SUM_MIN[Q_W-1:0];
        end
        else
        begin
            sat_w = sum_w[Q_W-1:0];
        end
    end

    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    // Sequencer, configuration register and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_points_reg  <= N_POINTS_RESET;
            idx_reg       <= '0;
            n_last_reg    <= '0;
            t_q_reg       <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            seg_reg       <= '0;
            dt_reg        <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            y_final_reg   <= '0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_y_reg     <= '0;
            out_oor_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                n_points_reg <= cfg_wdata;
            end

            // Drop the output beat once taken, refill from the finish state
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
                out_y_reg     <= y_final_reg;
                out_oor_reg   <= oor_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (query_fire)
                    begin
                        t_q_reg    <= req.arg_t;
                        idx_reg    <= '0;
                        n_last_reg <= IDX_W'(n_clip - 1'b1);
                        if (n_small)
                        begin
                            y_final_reg <= '0;
                            oor_reg     <= 1'b1;
                            state_reg   <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    // First read primes the left breakpoint
                    if (idx_reg == '0)
                    begin
                        prev_reg <= rd_data_reg;
                        idx_reg  <= IDX_W'(idx_reg + 1'b1);
                    end
                    else if (in_seg)
                    begin
                        cur_reg   <= rd_data_reg;
                        state_reg <= S_PREP;
                    end
                    else if (idx_reg == n_last_reg)
                    begin
                        y_final_reg <= '0;
                        oor_reg     <= 1'b1;
                        state_reg   <= S_FIN;
                    end
                    else
                    begin
                        prev_reg <= rd_data_reg;
                        idx_reg  <= IDX_W'(idx_reg + 1'b1);
                    end
                end

                S_PREP:
                begin
                    seg_reg <= seg_w[Q_W-1:0];
                    dt_reg  <= dt_w[Q_W-1:0];
                    mag_reg <= mag_w[Q_W-1:0];
                    neg_reg <= dy_w[Q_W];
                    oor_reg <= 1'b0;
                    // Zero-width segment returns its left y
                    if (seg_w == '0)
                    begin
                        y_final_reg <= prev_reg.y;
                        state_reg   <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SUM;
                    end
                end

                S_SUM:
                begin
                    y_final_reg <= sat_w;
                    state_reg   <= S_FIN;
                end

                S_FIN:
                begin
                    if (fin_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.y_result     = out_y_reg;
    assign rsp.out_of_range = out_oor_reg;

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.out_of_range |-> rsp.y_result == '0)
        else $error("out-of-range beat carries a nonzero y");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> seg_reg != '0)
        else $error("divider started on a zero-width segment");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> idx_reg <= n_last_reg)
        else $error("scan ran past the last breakpoint in use");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && out_valid_reg && !rsp.ready |=> state_reg == S_FIN)
        else $error("result left the finish state while the output was full");
`endif

endmodule
